// ===== rtl/core/bes_pkg.sv =====
// ----------------------------------------------------------------------------
// bes_pkg: shared types for the envelope segment stepper
// Step modes, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bes_pkg;

  // Input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Step mode picked on a segment load
  typedef enum logic [1:0] {
    MODE_FLAT    = 2'd0,
    MODE_UNIT    = 2'd1,
    MODE_SHALLOW = 2'd2,
    MODE_STEEP   = 2'd3
  } mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV   = 2'd1,
    ST_APPLY = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // latch a new segment
    logic step;       // single-step tick update
    logic div_start;  // seed the divider from the error term
    logic div_step;   // one restoring-division bit
    logic div_apply;  // advance by quotient + 1, fix error from remainder
    logic emit;       // load the output register from the current level
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_div;   // steep segment with a negative error term
    logic div_last;   // divider is on its final bit
  } status_t;

endpackage

// ===== rtl/core/bes_if.sv =====
// ----------------------------------------------------------------------------
// bes_if: valid/ready channels of the envelope segment stepper
// Input channel carries load and tick items; output channel carries levels.
// ----------------------------------------------------------------------------
interface bes_in_if #(
  parameter int LENGTH_BITS = 24,
  parameter int LEVEL_BITS  = 16
) ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [LENGTH_BITS-1:0] seg_length;
  logic [LEVEL_BITS-1:0]  seg_height;
  logic                   falling;

  modport source (output valid, kind, seg_length, seg_height, falling, input ready);
  modport sink   (input valid, kind, seg_length, seg_height, falling, output ready);
endinterface

interface bes_out_if #(
  parameter int LEVEL_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

// ===== rtl/core/bes_ctrl.sv =====
// ----------------------------------------------------------------------------
// bes_ctrl: sequencing state machine
// Accepts items when idle, runs the divider for steep ticks with a negative
// error term and hands each tick result to the output register.
// ----------------------------------------------------------------------------
module bes_ctrl
  import bes_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_TICK) begin
          state_nxt = status.need_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs / commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_LOAD) cmd.load = 1'b1;
          else if (status.need_div) cmd.div_start = 1'b1;
          else cmd.step = 1'b1;
        end
      end
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_APPLY: cmd.div_apply = 1'b1;
      ST_EMIT:  cmd.emit      = out_free;
      default:  cmd           = '0;
    endcase
  end

  // Output beat pending flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // never overwrite a beat that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("bes_ctrl: emit while output beat pending");

  // a tick that needs no division goes straight to emit
  a_tick_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_kind == KIND_TICK && !status.need_div)
    |=> state_r == ST_EMIT)
    else $error("bes_ctrl: simple tick did not reach emit");

  // divider runs until its last bit
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !status.div_last) |=> state_r == ST_DIV)
    else $error("bes_ctrl: divider left early");

  // a new beat only follows the emit state
  a_rise_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("bes_ctrl: output beat without emit");
`endif

endmodule

// ===== rtl/core/bes_dpath.sv =====
// ----------------------------------------------------------------------------
// bes_dpath: segment state, stepper arithmetic and serial divider
// Holds the segment registers, the restoring divider used by steep ticks
// and the output level register.
// ----------------------------------------------------------------------------
module bes_dpath
  import bes_pkg::*;
#(
  parameter int LENGTH_BITS = 24,
  parameter int LEVEL_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LENGTH_BITS-1:0] in_seg_length,
  input  logic [LEVEL_BITS-1:0]  in_seg_height,
  input  logic                   in_falling,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [LEVEL_BITS-1:0]  out_level
);

  localparam int LB = LENGTH_BITS;
  localparam int VB = LEVEL_BITS;
  localparam int EW = ((LB > VB) ? LB : VB) + 3;   // error term, two's complement
  localparam int CW = $clog2(VB + 1);              // divider bit counter
  localparam int AW = VB + 2;                      // position + advance

  // Segment state
  mode_t           mode_r, mode_nxt;
  logic [LB:0]     tlen_r, tlen_nxt;
  logic [VB:0]     thgt_r, thgt_nxt;
  logic [EW-1:0]   err_r, err_nxt;
  logic [VB-1:0]   pos_r, pos_nxt;
  logic [VB-1:0]   span_r, span_nxt;
  logic            down_r, down_nxt;

  // Divider and output
  logic [LB:0]     rem_r, rem_nxt;
  logic [VB:0]     dvd_r, dvd_nxt;   // dividend in, quotient out
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [VB-1:0]   out_level_r;

  logic [EW-1:0]   len_e, ht_e, tlen_e, thgt_e, neg_err;
  logic [LB+1:0]   shl, diff;
  logic            ge;
  logic [AW-1:0]   amount, pos_sum;
  logic [VB-1:0]   pos_sat, level_c;

  assign len_e   = EW'(in_seg_length);
  assign ht_e    = EW'(in_seg_height);
  assign tlen_e  = EW'(tlen_r);
  assign thgt_e  = EW'(thgt_r);
  assign neg_err = '0 - err_r;

  // Restoring divider bit
  assign shl  = {rem_r, dvd_r[VB]};
  assign ge   = shl >= {1'b0, tlen_r};
  assign diff = shl - {1'b0, tlen_r};

  // Saturating advance: quotient + 1 after division, else 1
  assign amount  = cmd.div_apply ? (AW'(dvd_r) + AW'(1)) : AW'(1);
  assign pos_sum = AW'(pos_r) + amount;
  assign pos_sat = (pos_sum > AW'(span_r)) ? span_r : pos_sum[VB-1:0];

  // Level seen by a tick
  always_comb begin
    if (mode_r == MODE_FLAT) level_c = down_r ? '0 : span_r;
    else level_c = down_r ? (span_r - pos_r) : pos_r;
  end

  assign status.need_div = (mode_r == MODE_STEEP) && err_r[EW-1];
  assign status.div_last = (cnt_r == '0);
  assign out_level       = out_level_r;

  // Next-state logic
  always_comb begin
    mode_nxt = mode_r;
    tlen_nxt = tlen_r;
    thgt_nxt = thgt_r;
    err_nxt  = err_r;
    pos_nxt  = pos_r;
    span_nxt = span_r;
    down_nxt = down_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;

    if (cmd.load) begin
      down_nxt = in_falling;
      span_nxt = in_seg_height;
      pos_nxt  = '0;
      tlen_nxt = '0;
      thgt_nxt = '0;
      err_nxt  = '0;
      if (len_e == '0 || ht_e == '0) begin
        mode_nxt = MODE_FLAT;
      end else if (len_e == ht_e) begin
        mode_nxt = MODE_UNIT;
      end else begin
        tlen_nxt = {in_seg_length, 1'b0};
        thgt_nxt = {in_seg_height, 1'b0};
        if (len_e > ht_e) begin
          mode_nxt = MODE_SHALLOW;
          err_nxt  = {ht_e[EW-2:0], 1'b0} - len_e;
        end else begin
          mode_nxt = MODE_STEEP;
          err_nxt  = {len_e[EW-2:0], 1'b0} - ht_e;
        end
      end
    end

    // tick update without the divider
    if (cmd.step) begin
      case (mode_r)
        MODE_FLAT: pos_nxt = pos_r;
        MODE_UNIT: pos_nxt = pos_sat;
        MODE_SHALLOW: begin
          if (!err_r[EW-1]) begin
            err_nxt = err_r - tlen_e + thgt_e;
            pos_nxt = pos_sat;
          end else begin
            err_nxt = err_r + thgt_e;
          end
        end
        MODE_STEEP: begin
          // non-negative error: advance by one
          err_nxt = err_r + tlen_e - thgt_e;
          pos_nxt = pos_sat;
        end
        default: pos_nxt = pos_r;
      endcase
    end

    // divider
    if (cmd.div_start) begin
      dvd_nxt = neg_err[VB:0];
      rem_nxt = '0;
      cnt_nxt = CW'(VB);
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? diff[LB:0] : shl[LB:0];
      dvd_nxt = {dvd_r[VB-1:0], ge};
      cnt_nxt = cnt_r - CW'(1);
    end

    // e + tlen*(q+1) == tlen - r
    if (cmd.div_apply) begin
      pos_nxt = pos_sat;
      err_nxt = tlen_e - EW'(rem_r) - thgt_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FLAT;
      tlen_r <= '0;
      thgt_r <= '0;
      err_r  <= '0;
      pos_r  <= '0;
      span_r <= '0;
      down_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      tlen_r <= tlen_nxt;
      thgt_r <= thgt_nxt;
      err_r  <= err_nxt;
      pos_r  <= pos_nxt;
      span_r <= span_nxt;
      down_r <= down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.emit) out_level_r <= level_c;
  end

`ifndef NO_ASSERTIONS
  // position saturates at the span
  a_pos_span: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= span_r)
    else $error("bes_dpath: position beyond span");

  // flat and unit segments keep a zero error term
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_FLAT || mode_r == MODE_UNIT) |-> err_r == '0)
    else $error("bes_dpath: error term set in flat or unit mode");
`endif

endmodule

// ===== rtl/core/bresenham_envelope_segment.sv =====
// ----------------------------------------------------------------------------
// bresenham_envelope_segment: linear envelope segment generator
// Midpoint line stepper producing one envelope level per sample tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready) carries items: kind 0 loads a segment (seg_length,
//          seg_height, falling), kind 1 is one sample tick.
//   out_ch (valid/ready) returns one level per tick; loads return nothing.
// Timing: an item is taken only while the controller is idle. A load is
//   taken in the idle state, which the controller keeps. A tick passes to
//   the emit state and then to its output beat; a steep-segment tick
//   with a negative error term runs the restoring divider, one quotient bit
//   a cycle, going from idle through the divide and apply states to emit.
//   No new item is taken until a tick has left its emit state.
// Stall: a finished level sits in the output register; the next item is
//   still taken, and a following tick waits in its emit state until the
//   receiver takes the pending beat.
// Reset: synchronous, active low; the block comes up as a flat segment of
//   height zero, so ticks return 0 until a load.
// ----------------------------------------------------------------------------
module bresenham_envelope_segment
  import bes_pkg::*;
#(
  parameter int LENGTH_BITS = 24,
  parameter int LEVEL_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bes_in_if.sink    in_ch,
  bes_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  bes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bes_dpath #(
    .LENGTH_BITS (LENGTH_BITS),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_seg_length (in_ch.seg_length),
    .in_seg_height (in_ch.seg_height),
    .in_falling    (in_ch.falling),
    .cmd           (cmd),
    .status        (status),
    .out_level     (out_ch.level)
  );

endmodule
